@@ rtl/core/ciou_pkg.sv @@
// Shared types, constants and step functions for the Complete-IoU metric pipeline.
// Used by complete_iou_box_metric_top; no other dependencies.
package ciou_pkg;

  localparam int CoordBits   = 16;
  localparam int ResFracBits = 14;
  localparam int DivSteps    = ResFracBits + 1;
  localparam int RotSteps    = 16;
  localparam int NormBit     = 28;
  localparam int NumStages   = 39;
  localparam int InDataW     = 8 * CoordBits;
  localparam int OutDataW    = 32;

  localparam logic [16:0] QuarterTurn = 17'd65536;
  localparam logic [14:0] ResOne      = 15'd16384;

  // Long-division state: remainder, divisor, partial quotient, special-case flags.
  typedef struct packed {
    logic [37:0] rem;
    logic [37:0] den;
    logic [14:0] quo;
    logic        zero;
    logic        one;
  } div_t;

  // CORDIC vector and accumulated angle; wz marks a zero-width box.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [18:0] z;
    logic               wz;
  } cor_t;

  // Values carried along the alpha division.
  typedef struct packed {
    logic [14:0] iou;
    logic [14:0] rho;
    logic [14:0] v;
  } res_t;

  // atan(2^-i) in quarter turns scaled to 2^16
  function automatic logic [15:0] rot_angle(input int idx);
    logic [15:0] a;
    case (idx)
      0:       a = 16'd32768;
      1:       a = 16'd19344;
      2:       a = 16'd10221;
      3:       a = 16'd5188;
      4:       a = 16'd2604;
      5:       a = 16'd1303;
      6:       a = 16'd652;
      7:       a = 16'd326;
      8:       a = 16'd163;
      9:       a = 16'd81;
      10:      a = 16'd41;
      11:      a = 16'd20;
      12:      a = 16'd10;
      13:      a = 16'd5;
      14:      a = 16'd3;
      15:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Set up a ratio num/den.
  function automatic div_t div_init(input logic [37:0] num, input logic [37:0] den);
    div_t d;
    d.rem  = num;
    d.den  = den;
    d.quo  = '0;
    d.zero = (den == '0);
    d.one  = (num >= den);
    return d;
  endfunction

  // One restoring long-division step: one quotient bit.
  function automatic div_t div_step(input div_t a);
    logic [38:0] r2;
    div_t        b;
    b  = a;
    r2 = {a.rem, 1'b0};
    if (r2 >= {1'b0, a.den}) begin
      b.rem = 38'(r2 - {1'b0, a.den});
      b.quo = {a.quo[13:0], 1'b1};
    end else begin
      b.rem = r2[37:0];
      b.quo = {a.quo[13:0], 1'b0};
    end
    return b;
  endfunction

  // Round the extra quotient bit away, saturate at one.
  function automatic logic [14:0] div_final(input div_t a);
    logic [15:0] r;
    logic [14:0] q;
    r = ({1'b0, a.quo} + 16'd1) >> 1;
    if (a.zero) begin
      q = '0;
    end else if (a.one || (r > {1'b0, ResOne})) begin
      q = ResOne;
    end else begin
      q = r[14:0];
    end
    return q;
  endfunction

  // One vectoring CORDIC rotation.
  function automatic cor_t cor_step(input cor_t a, input int idx);
    cor_t b;
    b = a;
    if (!a.y[33]) begin
      b.x = a.x + (a.y >>> idx);
      b.y = a.y - (a.x >>> idx);
      b.z = a.z + 19'(rot_angle(idx));
    end else begin
      b.x = a.x - (a.y >>> idx);
      b.y = a.y + (a.x >>> idx);
      b.z = a.z - 19'(rot_angle(idx));
    end
    return b;
  endfunction

  // Normalize (x=h, y=w) so the larger reaches bit NormBit.
  function automatic cor_t cor_init(input logic [15:0] w, input logic [15:0] h);
    logic [15:0] m;
    logic [4:0]  p;
    logic [4:0]  s;
    cor_t        c;
    m = (w > h) ? w : h;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (m[i]) p = 5'(i);
    end
    s    = 5'(NormBit) - p;
    c.x  = $signed({18'd0, h} << s);
    c.y  = $signed({18'd0, w} << s);
    c.z  = '0;
    c.wz = (w == '0);
    return c;
  endfunction

  // Clamp the final angle to [0, quarter turn]; zero width gives zero.
  function automatic logic [16:0] cor_angle(input cor_t c);
    logic [16:0] a;
    if (c.wz || c.z[18]) begin
      a = '0;
    end else if (c.z > $signed({2'b00, QuarterTurn})) begin
      a = QuarterTurn;
    end else begin
      a = c.z[16:0];
    end
    return a;
  endfunction

endpackage

@@ rtl/core/complete_iou_box_metric_top.sv @@
// Complete-IoU metric for a pair of center/size boxes, fully pipelined.
// Depends on ciou_pkg for types, the CORDIC angle table and division steps.
//
// Takes one box pair per cycle on the slave stream and returns one item per pair
// on the master stream. The pipe has 39 register stages; the item is registered
// in the last stage. Each box is center x, center y, width,
// height in unsigned Q8.8. The result holds the Complete IoU in signed Q2.14
// (iou minus the normalized center distance minus the aspect penalty v*alpha)
// and the plain IoU in Q1.14. Ratios are 15-step long divisions, one quotient
// bit per stage; box angles use a 16-step vectoring CORDIC, one rotation per
// stage. Latency is set by the chain products -> iou/distance division ->
// alpha division, which run in series. A new pair enters every cycle; all
// stages advance together, so when the output item is not taken the whole
// pipe holds and s_axis_tready drops.
module complete_iou_box_metric_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_center_x, first_center_y, first_width, first_height,
  // second_center_x, second_center_y, second_width, second_height (16 bits each)
  input  logic [ciou_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ciou_value [15:0], plain_iou [30:16], zero [31]
  output logic [ciou_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int Ns = ciou_pkg::NumStages;

  logic adv;
  logic [Ns-1:0] vld_q;

  // Advance every stage when the output slot is free or being taken.
  assign adv           = !vld_q[Ns-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Ns-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Ns-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 1: corners in half-LSB units, overlap and enclosure extents
  logic [15:0] cx1, cy1, bw1, bh1, cx2, cy2, bw2, bh2;
  assign cx1 = s_axis_tdata[15:0];
  assign cy1 = s_axis_tdata[31:16];
  assign bw1 = s_axis_tdata[47:32];
  assign bh1 = s_axis_tdata[63:48];
  assign cx2 = s_axis_tdata[79:64];
  assign cy2 = s_axis_tdata[95:80];
  assign bw2 = s_axis_tdata[111:96];
  assign bh2 = s_axis_tdata[127:112];

  logic signed [19:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
  logic signed [19:0] iw_s, ih_s, cw_s, ch_s, dx_s, dy_s;

  always_comb begin
    ax1  = $signed({3'b0, cx1, 1'b0}) - $signed({4'b0, bw1});
    ax2  = $signed({3'b0, cx1, 1'b0}) + $signed({4'b0, bw1});
    ay1  = $signed({3'b0, cy1, 1'b0}) - $signed({4'b0, bh1});
    ay2  = $signed({3'b0, cy1, 1'b0}) + $signed({4'b0, bh1});
    bx1  = $signed({3'b0, cx2, 1'b0}) - $signed({4'b0, bw2});
    bx2  = $signed({3'b0, cx2, 1'b0}) + $signed({4'b0, bw2});
    by1  = $signed({3'b0, cy2, 1'b0}) - $signed({4'b0, bh2});
    by2  = $signed({3'b0, cy2, 1'b0}) + $signed({4'b0, bh2});
    iw_s = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
    ih_s = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
    cw_s = ((ax2 > bx2) ? ax2 : bx2) - ((ax1 < bx1) ? ax1 : bx1);
    ch_s = ((ay2 > by2) ? ay2 : by2) - ((ay1 < by1) ? ay1 : by1);
    dx_s = $signed({3'b0, cx1, 1'b0}) - $signed({3'b0, cx2, 1'b0});
    dy_s = $signed({3'b0, cy1, 1'b0}) - $signed({3'b0, cy2, 1'b0});
  end

  logic [17:0]        iw_q, ih_q, cw_q, ch_q;
  logic signed [17:0] dx_q, dy_q;
  logic [15:0]        w1_q, h1_q, w2_q, h2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      iw_q <= iw_s[19] ? '0 : iw_s[17:0];
      ih_q <= ih_s[19] ? '0 : ih_s[17:0];
      cw_q <= cw_s[17:0];
      ch_q <= ch_s[17:0];
      dx_q <= dx_s[17:0];
      dy_q <= dy_s[17:0];
      w1_q <= bw1;
      h1_q <= bh1;
      w2_q <= bw2;
      h2_q <= bh2;
    end
  end

  // ---- stage 2: products; normalize CORDIC start vectors
  logic [35:0] inter_q, cww_q, chh_q;
  logic [33:0] ar1_q, ar2_q, dxx_q, dyy_q;
  logic signed [35:0] dxx_w, dyy_w;
  ciou_pkg::cor_t cor1_q [0:ciou_pkg::RotSteps];
  ciou_pkg::cor_t cor2_q [0:ciou_pkg::RotSteps];

  assign dxx_w = dx_q * dx_q;
  assign dyy_w = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inter_q   <= iw_q * ih_q;
      cww_q     <= cw_q * cw_q;
      chh_q     <= ch_q * ch_q;
      ar1_q     <= {w1_q, 1'b0} * {h1_q, 1'b0};
      ar2_q     <= {w2_q, 1'b0} * {h2_q, 1'b0};
      dxx_q     <= dxx_w[33:0];
      dyy_q     <= dyy_w[33:0];
    end
  end

  // ---- stage 2: CORDIC start vectors; stages 3..18: rotations, one per stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor1_q[0] <= ciou_pkg::cor_init(w1_q, h1_q);
      cor2_q[0] <= ciou_pkg::cor_init(w2_q, h2_q);
      for (int i = 0; i < ciou_pkg::RotSteps; i++) begin
        cor1_q[i+1] <= ciou_pkg::cor_step(cor1_q[i], i);
        cor2_q[i+1] <= ciou_pkg::cor_step(cor2_q[i], i);
      end
    end
  end

  // ---- stage 3: union, distances; stages 4..18: iou and distance divisions
  logic [37:0] uni_w, rho2_w, c2_w;
  assign uni_w  = 38'(ar1_q) + 38'(ar2_q) - 38'(inter_q);
  assign rho2_w = 38'(dxx_q) + 38'(dyy_q);
  assign c2_w   = 38'(cww_q) + 38'(chh_q);

  ciou_pkg::div_t dvi_q [0:ciou_pkg::DivSteps];
  ciou_pkg::div_t dvr_q [0:ciou_pkg::DivSteps];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dvi_q[0] <= ciou_pkg::div_init(38'(inter_q), uni_w);
      dvr_q[0] <= ciou_pkg::div_init(rho2_w, c2_w);
      for (int j = 0; j < ciou_pkg::DivSteps; j++) begin
        dvi_q[j+1] <= ciou_pkg::div_step(dvi_q[j]);
        dvr_q[j+1] <= ciou_pkg::div_step(dvr_q[j]);
      end
    end
  end

  // ---- stage 19: round ratios, clamp angles, take the angle difference
  logic [16:0] ang1, ang2;
  assign ang1 = ciou_pkg::cor_angle(cor1_q[ciou_pkg::RotSteps]);
  assign ang2 = ciou_pkg::cor_angle(cor2_q[ciou_pkg::RotSteps]);

  logic [14:0] iou19_q, rho19_q;
  logic [16:0] dlt_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      iou19_q <= ciou_pkg::div_final(dvi_q[ciou_pkg::DivSteps]);
      rho19_q <= ciou_pkg::div_final(dvr_q[ciou_pkg::DivSteps]);
      dlt_q   <= (ang2 > ang1) ? (ang2 - ang1) : (ang1 - ang2);
    end
  end

  // ---- stage 20: v = d^2 rounded from Q32 to the result scale
  logic [33:0] vq_w;
  logic [33:0] vr_w;
  assign vq_w = dlt_q * dlt_q;
  assign vr_w = vq_w + (34'd1 << (31 - ciou_pkg::ResFracBits));

  ciou_pkg::res_t car_q [0:18];
  ciou_pkg::div_t dva_q [0:ciou_pkg::DivSteps];
  logic [14:0]    alpha_q;
  logic [14:0]    va_q;
  logic [29:0]    vap_w;
  logic [29:0]    var_w;
  logic [15:0]    den_w;

  assign den_w = 16'(ciou_pkg::ResOne) - 16'(car_q[0].iou) + 16'(car_q[0].v);
  assign vap_w = car_q[17].v * alpha_q;
  assign var_w = vap_w + (30'd1 << (ciou_pkg::ResFracBits - 1));

  // ---- stages 21..36: alpha division; 37: round; 38: v*alpha
  always_ff @(posedge clk_i) begin
    if (adv) begin
      car_q[0].iou <= iou19_q;
      car_q[0].rho <= rho19_q;
      car_q[0].v   <= vr_w[32:18];
      for (int k = 0; k < 18; k++) begin
        car_q[k+1] <= car_q[k];
      end
      dva_q[0] <= ciou_pkg::div_init(38'(car_q[0].v), 38'(den_w));
      for (int j = 0; j < ciou_pkg::DivSteps; j++) begin
        dva_q[j+1] <= ciou_pkg::div_step(dva_q[j]);
      end
      alpha_q <= ciou_pkg::div_final(dva_q[ciou_pkg::DivSteps]);
      va_q    <= var_w[28:14];
    end
  end

  // ---- stage 39: combine, saturate and hold the output item
  logic signed [17:0] ciou_w;
  logic [15:0]        ciou_q;
  logic [14:0]        piou_q;

  assign ciou_w = $signed({3'b0, car_q[18].iou}) - $signed({3'b0, car_q[18].rho})
                - $signed({3'b0, va_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ciou_w < -18'sd32768) begin
        ciou_q <= 16'h8000;
      end else if (ciou_w > 18'sd32767) begin
        ciou_q <= 16'h7fff;
      end else begin
        ciou_q <= ciou_w[15:0];
      end
      piou_q <= car_q[18].iou;
    end
  end

  assign m_axis_tdata = {1'b0, piou_q, ciou_q};

endmodule

@@ bench/complete_iou_box_metric_top_tb.sv @@
// Self-checking bench for complete_iou_box_metric_top: box pairs in, CIoU and IoU out.
// Predicts most results with a local integer CIoU model; needs ciou_pkg and the top.
`timescale 1ns / 1ps

module complete_iou_box_metric_top_tb;

  localparam int StallLimit = 2000;
  localparam int Latency    = 39;

  typedef struct {
    logic [15:0] ciou;
    logic [14:0] iou;
  } metric_t;

  typedef struct {
    logic [15:0] box [8];
    bit          known;
    logic [15:0] ciou;
    logic [14:0] iou;
  } row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [ciou_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [ciou_pkg::OutDataW-1:0] m_axis_tdata;

  metric_t pending_q [$];
  int      mismatches;
  int      idle_cycles;
  int      sent_count;
  int      got_count;
  bit      calm;
  bit      run_done;

  complete_iou_box_metric_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Rounded ratio num/den in Q.14, saturated at one; zero when den is zero.
  function automatic longint unsigned frac_of(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = num;
    if (den == 0) return 0;
    if (num >= den) return 64'd16384;
    for (int i = 0; i <= 14; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    q = (q + 1) >> 1;
    return (q > 16384) ? 64'd16384 : q;
  endfunction

  // Vectoring CORDIC angle of (x=h, y=w) in quarter turns * 2^16.
  function automatic longint aspect_angle(longint w, longint h);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint ny;
    x = h;
    y = w;
    z = 0;
    if (w == 0) return 0;
    while (x < (64'sd1 << 28) && y < (64'sd1 << 28)) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ciou_pkg::rot_angle(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ciou_pkg::rot_angle(i));
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > 65536) z = 65536;
    return z;
  endfunction

  function automatic metric_t predict_metric(logic [15:0] b [8]);
    longint f [8];
    longint ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, iw, ih, cw, ch, dx, dy, d, c;
    longint unsigned inter, uni, iou, rho, v, va, alpha;
    metric_t m;
    foreach (f[i]) f[i] = longint'(b[i]);
    ax1 = 2 * f[0] - f[2];
    ax2 = 2 * f[0] + f[2];
    ay1 = 2 * f[1] - f[3];
    ay2 = 2 * f[1] + f[3];
    bx1 = 2 * f[4] - f[6];
    bx2 = 2 * f[4] + f[6];
    by1 = 2 * f[5] - f[7];
    by2 = 2 * f[5] + f[7];
    iw = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
    ih = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    uni   = 4 * f[2] * f[3] + 4 * f[6] * f[7] - inter;
    iou   = frac_of(inter, uni);
    dx  = 2 * (f[0] - f[4]);
    dy  = 2 * (f[1] - f[5]);
    cw  = ((ax2 > bx2) ? ax2 : bx2) - ((ax1 < bx1) ? ax1 : bx1);
    ch  = ((ay2 > by2) ? ay2 : by2) - ((ay1 < by1) ? ay1 : by1);
    rho = frac_of(dx * dx + dy * dy, cw * cw + ch * ch);
    d = aspect_angle(f[6], f[7]) - aspect_angle(f[2], f[3]);
    if (d < 0) d = -d;
    v     = (d * d + (64'd1 << 17)) >> 18;
    alpha = frac_of(v, 16384 - iou + v);
    va    = (v * alpha + 8192) >> 14;
    c = longint'(iou) - longint'(rho) - longint'(va);
    if (c < -32768) c = -32768;
    if (c > 32767) c = 32767;
    m.ciou = c[15:0];
    m.iou  = (iou > 32767) ? 15'h7fff : iou[14:0];
    return m;
  endfunction

  function automatic logic [ciou_pkg::InDataW-1:0] pack_boxes(logic [15:0] b [8]);
    logic [ciou_pkg::InDataW-1:0] p;
    foreach (b[i]) p[16*i +: 16] = b[i];
    return p;
  endfunction

  // Present one pair and hold it until taken; random gaps go in front.
  task automatic send_pair(logic [15:0] b [8], bit known, metric_t given);
    metric_t m;
    m = predict_metric(b);
    if (known) m = given;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_boxes(b);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.insert(pending_q.size(), m);
    sent_count++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 3));
      2:       return 16'hffff - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(256, 8191));
    endcase
  endfunction

  // Receiver: random stall bursts, compare each item against the oldest prediction.
  initial begin
    metric_t m;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got_count++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output item %h", m_axis_tdata);
        end else begin
          m = pending_q.pop_front();
          if (m_axis_tdata[15:0] !== m.ciou || m_axis_tdata[30:16] !== m.iou) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item %0d: exp ciou %h iou %h, got ciou %h iou %h", got_count,
                       m.ciou, m.iou, m_axis_tdata[15:0], m_axis_tdata[30:16]);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit && !run_done) begin
        $display("complete_iou_box_metric_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    row_t        rows [$];
    row_t        r;
    metric_t     given;
    logic [15:0] b [8];
    logic [15:0] s;
    int          pad;
    sent_count    = 0;
    calm          = 1'b0;
    run_done      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: known answers where obvious, rest predicted.
    r.known = 1'b1;  // all zero: zero union, zero diagonal, zero widths
    r.box = '{0, 0, 0, 0, 0, 0, 0, 0}; r.ciou = 16'd0; r.iou = 15'd0;
    rows.insert(rows.size(), r);
    r.box = '{16'h0800, 16'h0800, 16'h0200, 16'h0200, 16'h0800, 16'h0800, 16'h0200,
              16'h0200};
    r.ciou = 16'd16384; r.iou = 15'd16384; rows.insert(rows.size(), r);  // identical boxes
    r.box = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
              16'hffff};
    r.ciou = 16'd16384; r.iou = 15'd16384; rows.insert(rows.size(), r);
    r.known = 1'b0;
    r.box = '{0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
    rows.insert(rows.size(), r);
    r.box = '{0, 0, 16'h0100, 16'h0100, 16'hffff, 16'hffff, 16'h0100, 16'h0100};
    rows.insert(rows.size(), r);  // far apart, disjoint
    r.box = '{16'h0400, 16'h0400, 16'h0100, 0, 16'h0400, 16'h0400, 16'h0100, 16'h0100};
    rows.insert(rows.size(), r);  // zero height with width
    r.box = '{16'h0400, 16'h0400, 0, 16'h0100, 16'h0400, 16'h0400, 16'h0100, 16'h0100};
    rows.insert(rows.size(), r);  // zero width
    r.box = '{16'h0400, 16'h0400, 16'hffff, 1, 16'h0400, 16'h0400, 1, 16'hffff};
    rows.insert(rows.size(), r);  // opposite extreme aspects
    r.box = '{16'h0400, 16'h0400, 16'h0200, 16'h0100, 16'h0480, 16'h0420, 16'h0100,
              16'h0300};
    rows.insert(rows.size(), r);
    r.box = '{1, 1, 1, 1, 0, 0, 1, 1}; rows.insert(rows.size(), r);
    r.box = '{16'h8000, 16'h0001, 16'h4000, 16'h0002, 16'h7fff, 16'h0003, 16'h4001,
              16'h0002};
    rows.insert(rows.size(), r);
    r.box = '{16'h0400, 16'h0400, 16'h0800, 16'h0800, 16'h0400, 16'h0400, 16'h0100,
              16'h0100};
    rows.insert(rows.size(), r);  // nested
    foreach (rows[i]) begin
      given.ciou = rows[i].ciou;
      given.iou  = rows[i].iou;
      send_pair(rows[i].box, rows[i].known, given);
    end

    // Random: mostly overlapping neighbours, some raw noise.
    for (int n = 0; n < 1250; n++) begin
      if (n == 600) begin
        // drain completely before resuming
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      if (n == 1100) calm = 1'b1;
      foreach (b[i]) b[i] = rand_coord();
      if ($urandom_range(0, 3) != 0) begin
        s = 16'($urandom_range(0, 1023));
        pad = $urandom_range(0, 1);
        b[4] = pad ? b[0] + s : b[0] - s;
        b[5] = pad ? b[1] - s : b[1] + s;
        if (b[0] > 16'hf000) b[4] = b[0] - s;
        if (b[1] > 16'hf000) b[5] = b[1] - s;
        if (b[0] < 16'h0400) b[4] = b[0] + s;
        if (b[1] < 16'h0400) b[5] = b[1] + s;
      end
      send_pair(b, 1'b0, given);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    run_done = 1'b1;
    $display("Sent %0d box pairs (directed edges, zero sizes, random overlaps),", sent_count);
    $display("checked %0d results with random stalls on both streams.", got_count);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("complete_iou_box_metric_top_tb OK");
    end else begin
      $display("complete_iou_box_metric_top_tb NOT OK");
    end
    $finish;
  end

endmodule
